### hw/rtl/morton_neighbor_index_generator_assert.svh
// ----------------------------------------------------------------------------
// Morton neighbour generator assertion macros
// Shared concurrent assertion forms used by the RTL of the neighbour generator.
// ----------------------------------------------------------------------------
`ifndef MORTON_NEIGHBOR_INDEX_GENERATOR_ASSERT_SVH
`define MORTON_NEIGHBOR_INDEX_GENERATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MNIG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MNIG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mnig_pkg.sv
// ----------------------------------------------------------------------------
// Morton neighbour generator package
// Shared constants, register codes and control structs of the neighbour generator.
// ----------------------------------------------------------------------------
package mnig_pkg;

   // default number of bits per coordinate axis
   localparam int MAX_AXIS_BITS_DEF = 10;

   // configuration register widths
   localparam int CFG_BITS_W  = 4;
   localparam int CFG_MAX_W   = 10;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;

   // reset values of the configuration registers
   localparam logic [CFG_BITS_W-1:0] AXIS_BITS_RST = 4'd10;
   localparam logic [CFG_MAX_W-1:0]  MAX_COORD_RST = 10'd1023;

   // neighbour count per centre fits in five bits (at most 26)
   localparam int REM_W = 5;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_AXIS_BITS = 2'd0,
      REG_MAX_I     = 2'd1,
      REG_MAX_J     = 2'd2,
      REG_MAX_K     = 2'd3
   } csr_reg_type;

   // per axis: number of components (1 to 3) and slot of the plain component
   typedef struct packed {
      logic [1:0] count;
      logic [1:0] centre;
   } axis_info_type;

   // hand-over of one centre from the component stage to the walker
   typedef struct packed {
      logic             load;
      logic [REM_W-1:0] total;
      axis_info_type    info_i;
      axis_info_type    info_j;
      axis_info_type    info_k;
   } job_ctrl_type;

endpackage

### hw/rtl/mnig_csr.sv
// ----------------------------------------------------------------------------
// Morton neighbour generator configuration registers
// Holds axis width and maxima, and derives the dilated k mask and axis bounds.
// ----------------------------------------------------------------------------
module mnig_csr #(
   parameter int MAX_AXIS_BITS = mnig_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   input  logic [mnig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mnig_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic [3*MAX_AXIS_BITS-1:0]         mask_k,
   output logic [3*MAX_AXIS_BITS-1:0]         bound_i,
   output logic [3*MAX_AXIS_BITS-1:0]         bound_j,
   output logic [3*MAX_AXIS_BITS-1:0]         bound_k
);

   localparam int IDX_W = 3 * MAX_AXIS_BITS;
   localparam int EXT_W = (MAX_AXIS_BITS > mnig_pkg::CFG_MAX_W) ?
                          MAX_AXIS_BITS : mnig_pkg::CFG_MAX_W;

   logic [mnig_pkg::CFG_BITS_W-1:0] axis_bits_ff;
   logic [mnig_pkg::CFG_MAX_W-1:0]  max_i_ff;
   logic [mnig_pkg::CFG_MAX_W-1:0]  max_j_ff;
   logic [mnig_pkg::CFG_MAX_W-1:0]  max_k_ff;
   logic [EXT_W-1:0]                max_i_ext;
   logic [EXT_W-1:0]                max_j_ext;
   logic [EXT_W-1:0]                max_k_ext;
   logic [IDX_W-1:0]                dil_i;
   logic [IDX_W-1:0]                dil_j;
   logic [IDX_W-1:0]                dil_k;

   // register writes, unknown indexes cannot occur with a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_bits_ff <= mnig_pkg::AXIS_BITS_RST;
         max_i_ff     <= mnig_pkg::MAX_COORD_RST;
         max_j_ff     <= mnig_pkg::MAX_COORD_RST;
         max_k_ff     <= mnig_pkg::MAX_COORD_RST;
      end else if (csr_valid) begin
         unique case (mnig_pkg::csr_reg_type'(csr_index))
            mnig_pkg::REG_AXIS_BITS: axis_bits_ff <= csr_data[mnig_pkg::CFG_BITS_W-1:0];
            mnig_pkg::REG_MAX_I:     max_i_ff     <= csr_data[mnig_pkg::CFG_MAX_W-1:0];
            mnig_pkg::REG_MAX_J:     max_j_ff     <= csr_data[mnig_pkg::CFG_MAX_W-1:0];
            mnig_pkg::REG_MAX_K:     max_k_ff     <= csr_data[mnig_pkg::CFG_MAX_W-1:0];
         endcase
      end
   end

   assign max_i_ext = EXT_W'(max_i_ff);
   assign max_j_ext = EXT_W'(max_j_ff);
   assign max_k_ext = EXT_W'(max_k_ff);

   // dilate mask and maxima: axis width of zero acts as one, saturates at the top
   always_comb begin
      mask_k = '0;
      dil_i  = '0;
      dil_j  = '0;
      dil_k  = '0;
      for (int b = 0; b < MAX_AXIS_BITS; b++) begin
         if ((b == 0) || (int'(axis_bits_ff) > b)) begin
            mask_k[3*b] = 1'b1;
            dil_i[3*b]  = max_i_ext[b];
            dil_j[3*b]  = max_j_ext[b];
            dil_k[3*b]  = max_k_ext[b];
         end
      end
   end

   // bounds sit at the lane of their axis
   assign bound_i = dil_i << 2;
   assign bound_j = dil_j << 1;
   assign bound_k = dil_k;

endmodule

### hw/rtl/mnig_axis.sv
// ----------------------------------------------------------------------------
// Morton neighbour generator axis unit
// Builds the minus, plain and plus dilated components of one coordinate axis.
// ----------------------------------------------------------------------------
module mnig_axis #(
   parameter int IDX_W = 3 * mnig_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic [IDX_W-1:0]          centre,
   input  logic [IDX_W-1:0]          mask,
   input  logic [IDX_W-1:0]          bound,
   output logic [2:0][IDX_W-1:0]     comp,
   output mnig_pkg::axis_info_type   info
);

   logic [IDX_W-1:0] plain;
   logic [IDX_W-1:0] minus;
   logic [IDX_W-1:0] plus;
   logic             has_minus;
   logic             has_plus;

   // masked dilated decrement and increment
   assign plain     = centre & mask;
   assign minus     = (plain - IDX_W'(1)) & mask;
   assign plus      = ((centre | ~mask) + IDX_W'(1)) & mask;
   assign has_minus = (plain != '0);
   assign has_plus  = (plain != bound);

   // pack present components in the order minus, plain, plus
   always_comb begin
      comp[0] = has_minus ? minus : plain;
      comp[1] = has_minus ? plain : plus;
      comp[2] = plus;
      info.count  = 2'd1 + {1'b0, has_minus} + {1'b0, has_plus};
      info.centre = {1'b0, has_minus};
   end

endmodule

### hw/rtl/mnig_walker.sv
// ----------------------------------------------------------------------------
// Morton neighbour generator walker
// Holds one centre's components and steps through all neighbour combinations.
// ----------------------------------------------------------------------------
`include "morton_neighbor_index_generator_assert.svh"

module mnig_walker #(
   parameter int IDX_W = 3 * mnig_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mnig_pkg::job_ctrl_type    job,
   input  logic [2:0][IDX_W-1:0]     comp_i,
   input  logic [2:0][IDX_W-1:0]     comp_j,
   input  logic [2:0][IDX_W-1:0]     comp_k,
   output logic                      job_free,
   output logic                      rsp_strobe,
   output logic [IDX_W-1:0]          rsp_neighbor_index,
   output logic                      rsp_last
);

   typedef struct packed {
      logic [1:0] a;
      logic [1:0] b;
      logic [1:0] d;
   } pos_type;

   logic                          job_valid_ff;
   logic                          job_valid_in;
   logic [mnig_pkg::REM_W-1:0]    remain_ff;
   pos_type                       pos_ff;
   mnig_pkg::axis_info_type       info_i_ff;
   mnig_pkg::axis_info_type       info_j_ff;
   mnig_pkg::axis_info_type       info_k_ff;
   logic [2:0][IDX_W-1:0]         comp_i_ff;
   logic [2:0][IDX_W-1:0]         comp_j_ff;
   logic [2:0][IDX_W-1:0]         comp_k_ff;
   logic                          rsp_strobe_ff;
   logic [IDX_W-1:0]              rsp_index_ff;
   logic [IDX_W-1:0]              rsp_index_in;
   logic                          rsp_last_ff;
   logic                          last_beat;
   logic                          on_centre;
   logic                          job_ends;
   pos_type                       first_pos;
   pos_type                       step_pos;
   pos_type                       next_pos;

   // mixed-radix step, k innermost
   function automatic pos_type step(input pos_type p, input mnig_pkg::axis_info_type jj,
                                    input mnig_pkg::axis_info_type kk);
      pos_type r;
      r = p;
      if (p.d + 2'd1 == kk.count) begin
         r.d = 2'd0;
         if (p.b + 2'd1 == jj.count) begin
            r.b = 2'd0;
            r.a = p.a + 2'd1;
         end else begin
            r.b = p.b + 2'd1;
         end
      end else begin
         r.d = p.d + 2'd1;
      end
      return r;
   endfunction

   function automatic logic is_centre(input pos_type p, input mnig_pkg::axis_info_type ii,
                                      input mnig_pkg::axis_info_type jj,
                                      input mnig_pkg::axis_info_type kk);
      return (p.a == ii.centre) && (p.b == jj.centre) && (p.d == kk.centre);
   endfunction

   // first combination of a new centre skips the centre itself
   always_comb begin
      first_pos = '0;
      if (is_centre(first_pos, job.info_i, job.info_j, job.info_k)) begin
         first_pos = step(first_pos, job.info_j, job.info_k);
      end
   end

   // next combination, skipping the centre once
   always_comb begin
      step_pos = step(pos_ff, info_j_ff, info_k_ff);
      next_pos = step_pos;
      if (is_centre(step_pos, info_i_ff, info_j_ff, info_k_ff)) begin
         next_pos = step(step_pos, info_j_ff, info_k_ff);
      end
   end

   // current neighbour and hand-over control
   assign last_beat    = (remain_ff == mnig_pkg::REM_W'(1));
   assign job_free     = !job_valid_ff || last_beat;
   assign rsp_index_in = comp_i_ff[pos_ff.a] | comp_j_ff[pos_ff.b] | comp_k_ff[pos_ff.d];

   always_comb begin
      job_valid_in = job_valid_ff;
      if (job.load) begin
         job_valid_in = 1'b1;
      end else if (last_beat) begin
         job_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         job_valid_ff  <= job_valid_in;
         rsp_strobe_ff <= job_valid_ff;
      end
   end

   // job and result payload
   always_ff @(posedge clock) begin
      if (job.load) begin
         pos_ff    <= first_pos;
         remain_ff <= job.total;
         info_i_ff <= job.info_i;
         info_j_ff <= job.info_j;
         info_k_ff <= job.info_k;
         comp_i_ff <= comp_i;
         comp_j_ff <= comp_j;
         comp_k_ff <= comp_k;
      end else if (job_valid_ff) begin
         pos_ff    <= next_pos;
         remain_ff <= remain_ff - mnig_pkg::REM_W'(1);
      end
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= last_beat;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_neighbor_index = rsp_index_ff;
   assign rsp_last           = rsp_last_ff;

   // check terms
   assign on_centre = is_centre(pos_ff, info_i_ff, info_j_ff, info_k_ff);
   assign job_ends  = job_valid_ff && last_beat && !job.load;

   // checks
   `MNIG_ASSERT_SAME(a_remain_live, clock, reset, job_valid_ff, remain_ff != '0, "no beats left")
   `MNIG_ASSERT_SAME(a_not_centre, clock, reset, job_valid_ff, !on_centre, "walker on centre cell")
   `MNIG_ASSERT_SAME(a_load_free, clock, reset, job.load, job_free, "load over busy job")
   `MNIG_ASSERT_NEXT(a_strobe, clock, reset, job_valid_ff, rsp_strobe_ff, "no result beat")
   `MNIG_ASSERT_NEXT(a_last_ends, clock, reset, job_ends, !job_valid_ff, "job outlived last beat")

endmodule

### hw/rtl/morton_neighbor_index_generator.sv
// ----------------------------------------------------------------------------
// Morton neighbour index generator
// Emits the Morton indices of the 3x3x3 neighbourhood of a centre cell.
// ----------------------------------------------------------------------------
// Usage:
//   A centre index is taken on a rising edge with start high and busy low. It
//   is registered, split into minus, plain and plus components per axis, and
//   handed to the walker, which puts out one neighbour index per cycle with
//   rsp_strobe high, i outermost, each axis in the order minus, plain, plus.
//   rsp_last marks the final neighbour of a centre; a centre without
//   neighbours gives no beat at all.
//   The centre passes through the input register, the walker's job registers
//   and the result register; a busy walker holds it in the input register.
//   The walker puts out one beat per cycle while it has a job; a centre gives
//   as many beats as it has neighbours (up to 26). One further centre waits in
//   the input register, so busy only rises while the walker is still working
//   and a centre is already waiting.
//   The receiver cannot stall: each beat is valid for exactly one cycle.
//   Configuration writes (csr_valid, csr_ready always high) must be made while
//   the block is idle; the block does not enforce this. Reset is synchronous:
//   it empties the pipeline and sets axis_bits to 10 and all maxima to 1023.
// ----------------------------------------------------------------------------
module morton_neighbor_index_generator #(
   parameter int MAX_AXIS_BITS = mnig_pkg::MAX_AXIS_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [3*MAX_AXIS_BITS-1:0]         req_center_index,
   output logic                               rsp_strobe,
   output logic [3*MAX_AXIS_BITS-1:0]         rsp_neighbor_index,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mnig_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mnig_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IDX_W = 3 * MAX_AXIS_BITS;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [IDX_W-1:0]              s1_index_ff;
   logic [IDX_W-1:0]              s1_index_in;
   logic                          accept;
   logic                          s1_advance;
   logic                          no_neighbours;
   logic                          job_free;
   logic [IDX_W-1:0]              mask_k;
   logic [IDX_W-1:0]              bound_i;
   logic [IDX_W-1:0]              bound_j;
   logic [IDX_W-1:0]              bound_k;
   logic [IDX_W-1:0]              centre;
   logic [2:0][IDX_W-1:0]         comp_i;
   logic [2:0][IDX_W-1:0]         comp_j;
   logic [2:0][IDX_W-1:0]         comp_k;
   mnig_pkg::axis_info_type       info_i;
   mnig_pkg::axis_info_type       info_j;
   mnig_pkg::axis_info_type       info_k;
   logic [mnig_pkg::REM_W-1:0]    combos;
   mnig_pkg::job_ctrl_type        job;

   // configuration registers
   assign csr_ready = 1'b1;

   mnig_csr #(
      .MAX_AXIS_BITS (MAX_AXIS_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .mask_k    (mask_k),
      .bound_i   (bound_i),
      .bound_j   (bound_j),
      .bound_k   (bound_k)
   );

   // input register handshake
   assign s1_advance  = s1_valid_ff && (no_neighbours || job_free);
   assign busy        = s1_valid_ff && !s1_advance;
   assign accept      = start && !busy;
   assign s1_valid_in = accept || busy;
   assign s1_index_in = accept ? req_center_index : s1_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= s1_index_in;
   end

   // per-axis components of the registered centre
   assign centre = s1_index_ff & (mask_k | (mask_k << 1) | (mask_k << 2));

   mnig_axis #(.IDX_W (IDX_W)) u_axis_i (
      .centre (centre),
      .mask   (mask_k << 2),
      .bound  (bound_i),
      .comp   (comp_i),
      .info   (info_i)
   );

   mnig_axis #(.IDX_W (IDX_W)) u_axis_j (
      .centre (centre),
      .mask   (mask_k << 1),
      .bound  (bound_j),
      .comp   (comp_j),
      .info   (info_j)
   );

   mnig_axis #(.IDX_W (IDX_W)) u_axis_k (
      .centre (centre),
      .mask   (mask_k),
      .bound  (bound_k),
      .comp   (comp_k),
      .info   (info_k)
   );

   // neighbour count is the product of component counts less the centre
   assign combos = mnig_pkg::REM_W'(info_i.count) * mnig_pkg::REM_W'(info_j.count)
                 * mnig_pkg::REM_W'(info_k.count);
   assign no_neighbours = (combos == mnig_pkg::REM_W'(1));

   always_comb begin
      job.load   = s1_valid_ff && !no_neighbours && job_free;
      job.total  = combos - mnig_pkg::REM_W'(1);
      job.info_i = info_i;
      job.info_j = info_j;
      job.info_k = info_k;
   end

   // neighbour walker and result register
   mnig_walker #(.IDX_W (IDX_W)) u_walker (
      .clock              (clock),
      .reset              (reset),
      .job                (job),
      .comp_i             (comp_i),
      .comp_j             (comp_j),
      .comp_k             (comp_k),
      .job_free           (job_free),
      .rsp_strobe         (rsp_strobe),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last           (rsp_last)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morton neighbour generator testbench
// Sends centre indices through the start/busy handshake and checks every
// neighbour beat, field by field, against an in-bench model of the 3x3x3
// neighbourhood walk. A short table of directed centres and register writes
// comes first, then phases of random centres under random axis settings.
// ----------------------------------------------------------------------------
module tb_top;
   import mnig_pkg::*;

   localparam int AXIS_N        = MAX_AXIS_BITS_DEF;
   localparam int IDX_W         = 3 * AXIS_N;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 8;
   localparam int PHASE_CENTRES = 21;
   localparam int PLAN_ROWS     = 28;

   typedef logic [IDX_W-1:0] morton_type;

   typedef enum logic {
      ROW_CENTRE,
      ROW_WRITE
   } row_kind_type;

   // one row of the directed plan; typed rows carry a hand-worked beat count
   // and the index of the beat that carries last
   typedef struct {
      row_kind_type          kind;
      csr_reg_type           target;
      logic [CSR_DATA_W-1:0] data;
      morton_type            centre;
      bit                    typed;
      int unsigned           count;
      morton_type            final_index;
   } plan_row_type;

   typedef struct {
      morton_type  index;
      logic        last;
      int unsigned seq;
   } neighbour_type;

   typedef struct {
      int unsigned count;
      morton_type  final_index;
   } want_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   morton_type             req_center_index;
   logic                   rsp_strobe;
   morton_type             rsp_neighbor_index;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   // shadow of the block's registers, kept by the monitor
   logic [CFG_BITS_W-1:0]  cfg_axis_bits;
   logic [CFG_MAX_W-1:0]   cfg_max_i;
   logic [CFG_MAX_W-1:0]   cfg_max_j;
   logic [CFG_MAX_W-1:0]   cfg_max_k;

   neighbour_type          pending_neighbours[$];
   want_type               typed_want[int unsigned];
   int unsigned            centre_seq;
   int unsigned            beat_run;
   int unsigned            sent;
   int unsigned            n_beats;
   int unsigned            n_writes;
   int unsigned            fault_count;

   // directed plan: extremes, wrap-around, saturation and empty neighbourhoods
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000000, 1'b1,  7, 30'h00000007},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h3FFFFFFF, 1'b1,  7, 30'h3FFFFFFE},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h15555555, 1'b0,  0, 30'h00000000},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h2AAAAAAA, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_AXIS_BITS, 10'h001, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_I,     10'h000, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_J,     10'h000, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_K,     10'h000, 30'h00000000, 1'b0,  0, 30'h00000000},
      // single cell grid: nothing around the centre
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000000, 1'b1,  0, 30'h00000000},
      // k above its maximum, plus wraps to zero
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000001, 1'b1,  2, 30'h00000000},
      // bits above the mask are ignored
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h3FFFFFF8, 1'b1,  0, 30'h00000000},
      // every axis above its maximum: full neighbourhood
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000007, 1'b1, 26, 30'h00000000},
      // zero axis width behaves as one bit, max_i wraps to 1
      '{ROW_WRITE,  REG_AXIS_BITS, 10'h000, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_I,     10'h003, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_J,     10'h001, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_K,     10'h001, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000000, 1'b1,  7, 30'h00000007},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000007, 1'b1,  7, 30'h00000006},
      // width 15 saturates to the full ten bits
      '{ROW_WRITE,  REG_AXIS_BITS, 10'h3FF, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_I,     10'h3FF, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_J,     10'h3FF, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_K,     10'h3FF, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h3FFFFFFF, 1'b1,  7, 30'h3FFFFFFE},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h00000000, 1'b1,  7, 30'h00000007},
      '{ROW_WRITE,  REG_AXIS_BITS, 10'h2C3, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_WRITE,  REG_MAX_J,     10'h005, 30'h00000000, 1'b0,  0, 30'h00000000},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h000001A5, 1'b0,  0, 30'h00000000},
      '{ROW_CENTRE, REG_AXIS_BITS, 10'h000, 30'h3FFFFE5A, 1'b0,  0, 30'h00000000}
   };

   morton_neighbor_index_generator uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_center_index   (req_center_index),
      .rsp_strobe         (rsp_strobe),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // axis width after clamping to 1 .. AXIS_N
   function automatic int unsigned eff_axis_bits(logic [CFG_BITS_W-1:0] b);
      if (b == '0) return 1;
      if (b > AXIS_N) return AXIS_N;
      return b;
   endfunction

   // place the low n bits of v at bit positions 0, 3, 6, ...
   function automatic morton_type spread(logic [AXIS_N-1:0] v, int unsigned n);
      morton_type r;
      r = '0;
      for (int b = 0; b < AXIS_N; b++) begin
         if (b < n) r[3*b] = v[b];
      end
      return r;
   endfunction

   // minus, plain and plus components of one axis; returns how many
   function automatic int unsigned axis_parts(morton_type c, morton_type m, morton_type bound,
                                              output logic [2:0][IDX_W-1:0] p);
      morton_type  v;
      int unsigned cnt;
      p   = '0;
      cnt = 0;
      v   = c & m;
      if (v != '0) begin
         p[cnt] = (v - 1'b1) & m;
         cnt++;
      end
      p[cnt] = v;
      cnt++;
      if (v != bound) begin
         p[cnt] = ((c | ~m) + 1'b1) & m;
         cnt++;
      end
      return cnt;
   endfunction

   // expected neighbour beats of one accepted centre
   task automatic predict_neighbours(morton_type raw);
      int unsigned          n;
      int unsigned          ni;
      int unsigned          nj;
      int unsigned          nk;
      morton_type           mk;
      morton_type           mj;
      morton_type           mi;
      morton_type           c;
      morton_type           z;
      logic [2:0][IDX_W-1:0] pi;
      logic [2:0][IDX_W-1:0] pj;
      logic [2:0][IDX_W-1:0] pk;
      neighbour_type        batch[$];
      neighbour_type        beat;
      n  = eff_axis_bits(cfg_axis_bits);
      mk = spread('1, n);
      mj = mk << 1;
      mi = mk << 2;
      c  = raw & (mi | mj | mk);
      ni = axis_parts(c, mi, spread(cfg_max_i, n) << 2, pi);
      nj = axis_parts(c, mj, spread(cfg_max_j, n) << 1, pj);
      nk = axis_parts(c, mk, spread(cfg_max_k, n), pk);
      // i outermost, each axis minus, plain, plus; the centre itself is skipped
      for (int a = 0; a < ni; a++) begin
         for (int b = 0; b < nj; b++) begin
            for (int d = 0; d < nk; d++) begin
               z = pi[a] | pj[b] | pk[d];
               if (z != c) begin
                  beat.index = z;
                  beat.last  = 1'b0;
                  beat.seq   = centre_seq;
                  batch      = {batch, beat};
               end
            end
         end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[q]) pending_neighbours = {pending_neighbours, batch[q]};
      centre_seq++;
   endtask

   // compare one result beat with the oldest expectation
   task automatic check_beat();
      neighbour_type head;
      want_type      want;
      if (pending_neighbours.size() == 0) begin
         $error("unexpected beat: neighbor_index %h last %b", rsp_neighbor_index, rsp_last);
         fault_count++;
      end else begin
         head = pending_neighbours.pop_front();
         n_beats++;
         beat_run++;
         if (rsp_neighbor_index !== head.index) begin
            $error("neighbor_index: expected %h, got %h", head.index, rsp_neighbor_index);
            fault_count++;
         end
         if (rsp_last !== head.last) begin
            $error("last: expected %b, got %b", head.last, rsp_last);
            fault_count++;
         end
         // closing beat of a hand-worked centre
         if (head.last) begin
            if (typed_want.exists(head.seq)) begin
               want = typed_want[head.seq];
               if (beat_run != want.count) begin
                  $error("beat count: expected %0d, got %0d", want.count, beat_run);
                  fault_count++;
               end
               if (rsp_neighbor_index !== want.final_index) begin
                  $error("final neighbor_index: expected %h, got %h",
                         want.final_index, rsp_neighbor_index);
                  fault_count++;
               end
               typed_want.delete(head.seq);
            end
            beat_run = 0;
         end
      end
   endtask

   // monitor: centres taken, beats out, register writes
   always @(posedge clock) begin
      if (reset) begin
         cfg_axis_bits = AXIS_BITS_RST;
         cfg_max_i     = MAX_COORD_RST;
         cfg_max_j     = MAX_COORD_RST;
         cfg_max_k     = MAX_COORD_RST;
      end else begin
         if (start && !busy) predict_neighbours(req_center_index);
         if (rsp_strobe) check_beat();
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               REG_AXIS_BITS: cfg_axis_bits = csr_data[CFG_BITS_W-1:0];
               REG_MAX_I:     cfg_max_i     = csr_data[CFG_MAX_W-1:0];
               REG_MAX_J:     cfg_max_j     = csr_data[CFG_MAX_W-1:0];
               REG_MAX_K:     cfg_max_k     = csr_data[CFG_MAX_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // one centre beat over start/busy
   task automatic send_centre(morton_type c);
      req_center_index <= c;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   // one register write; the caller drops csr_valid after the last of a group
   task automatic write_reg(csr_reg_type target, logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= target;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      n_writes++;
   endtask

   // wait until every expected beat is in, then let trailing empty centres drain
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (pending_neighbours.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // coordinate near the interesting points of an axis
   function automatic logic [AXIS_N-1:0] coord_pick(int unsigned lim, logic [CFG_MAX_W-1:0] top);
      int unsigned m;
      int unsigned r;
      m = top & lim;
      case ($urandom_range(0, 7))
         0:       r = 0;
         1:       r = m;
         2:       r = (m - 1) & lim;
         3:       r = (m + 1) & lim;
         4:       r = lim;
         default: r = $urandom & lim;
      endcase
      return r[AXIS_N-1:0];
   endfunction

   // random centre, mostly built from chosen coordinates
   function automatic morton_type pick_centre(logic [CFG_BITS_W-1:0] bits,
                                               logic [CFG_MAX_W-1:0] top_i,
                                               logic [CFG_MAX_W-1:0] top_j,
                                               logic [CFG_MAX_W-1:0] top_k);
      int unsigned n;
      int unsigned lim;
      morton_type  ones;
      morton_type  c;
      n    = eff_axis_bits(bits);
      lim  = (1 << n) - 1;
      ones = spread('1, n);
      if ($urandom_range(0, 7) == 0) return morton_type'($urandom);
      c = (spread(coord_pick(lim, top_i), n) << 2) | (spread(coord_pick(lim, top_j), n) << 1)
        | spread(coord_pick(lim, top_k), n);
      // junk above the mask now and then
      if ($urandom_range(0, 3) == 0)
         c = c | (morton_type'($urandom) & ~(ones | (ones << 1) | (ones << 2)));
      return c;
   endfunction

   // stimulus
   initial begin
      logic                  in_write;
      logic [CFG_BITS_W-1:0] ph_bits;
      logic [CFG_MAX_W-1:0]  ph_max [3];
      int unsigned           n;
      int unsigned           burst_left;
      int unsigned           gap;

      reset            = 1'b1;
      start            = 1'b0;
      req_center_index = '0;
      csr_valid        = 1'b0;
      csr_index        = REG_AXIS_BITS;
      csr_data         = '0;
      centre_seq       = 0;
      beat_run         = 0;
      sent             = 0;
      n_beats          = 0;
      n_writes         = 0;
      fault_count      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed plan
      in_write = 1'b0;
      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            if (!in_write) settle();
            write_reg(plan[r].target, plan[r].data);
            in_write = 1'b1;
         end else begin
            if (in_write) csr_valid <= 1'b0;
            in_write = 1'b0;
            if (plan[r].typed) typed_want[sent] = '{plan[r].count, plan[r].final_index};
            send_centre(plan[r].centre);
         end
      end

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       ph_bits = 4'd1;
            1:       ph_bits = 4'd10;
            2:       ph_bits = 4'd0;
            3:       ph_bits = 4'd15;
            default: ph_bits = 4'($urandom_range(0, 15));
         endcase
         n = eff_axis_bits(ph_bits);
         for (int a = 0; a < 3; a++) begin
            if (p == 1) ph_max[a] = '1;
            else if (p == 4) ph_max[a] = '0;
            else if ($urandom_range(0, 3) == 0) ph_max[a] = CFG_MAX_W'($urandom_range(0, 1023));
            else ph_max[a] = CFG_MAX_W'($urandom_range(0, (1 << n) - 1));
         end
         settle();
         write_reg(REG_AXIS_BITS, {6'($urandom), ph_bits});
         write_reg(REG_MAX_I, ph_max[0]);
         write_reg(REG_MAX_J, ph_max[1]);
         write_reg(REG_MAX_K, ph_max[2]);
         csr_valid <= 1'b0;

         // bursts of centres with random gaps between them
         burst_left = 0;
         for (int q = 0; q < PHASE_CENTRES; q++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
               if (q > 0 && gap > 0) begin
                  start <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            send_centre(pick_centre(ph_bits, ph_max[0], ph_max[1], ph_max[2]));
            burst_left--;
         end
      end

      settle();
      $display("summary: %0d centres, %0d neighbour beats checked, %0d register writes",
               sent, n_beats, n_writes);
      $display("summary: axis widths 0 to 15 incl. clamping, bursts and back-to-back centres");
      if (fault_count == 0 && pending_neighbours.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
